// ===== design/linear_byte_buffer_with_headroom_core_defines.svh =====
// assertion macros for the linear byte buffer core
// used by the checker module; no other dependencies
`ifndef LINEAR_BYTE_BUFFER_WITH_HEADROOM_CORE_DEFINES_SVH
`define LINEAR_BYTE_BUFFER_WITH_HEADROOM_CORE_DEFINES_SVH

// property checked on the rising clock, off while reset is asserted
`define LBBH_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on the rising clock at all times
`define LBBH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/lbbh_pkg.sv =====
// shared types and constants for the linear byte buffer core
// no dependencies
`default_nettype none

package lbbh_pkg;

	localparam int IDX_W     = 12;
	localparam int BYTE_W    = 8;
	localparam int CMD_W     = 3;
	localparam int REG_IDX_W = 2;
	localparam int EXT_W     = 17;

	localparam int STORE_DEPTH_DEF = 2048;

	localparam logic [IDX_W-1:0] HEADROOM_RST = 12'd0;
	localparam logic [IDX_W-1:0] CAPACITY_RST = 12'd2048;

	localparam logic [REG_IDX_W-1:0] REG_HEADROOM = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 2'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND  = 3'd0,
		CMD_POP     = 3'd1,
		CMD_PEEK    = 3'd2,
		CMD_PREPEND = 3'd3,
		CMD_COMPACT = 3'd4,
		CMD_CLEAR   = 3'd5
	} cmd_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic apply;
		logic copy_start;
		logic copy_run;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic needs_move;
		logic copy_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/lbbh_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lbbh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/lbbh_ctrl.sv =====
// controller state machine for the linear byte buffer core
// depends on lbbh_pkg
`default_nettype none

module lbbh_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire lbbh_pkg::sts_t sts,
	output lbbh_pkg::ctl_t     ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   stall_q;

	assign in_stall = stall_q;

	always_comb begin
		ctl            = '0;
		ctl.accept     = (state_q == ST_IDLE) && in_valid;
		ctl.apply      = (state_q == ST_EXEC) && !sts.needs_move && sts.out_free;
		ctl.copy_start = (state_q == ST_EXEC) && sts.needs_move;
		ctl.copy_run   = (state_q == ST_COPY);
		ctl.finish     = (state_q == ST_FINISH) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
						stall_q <= 1'b1;
					end
				end
				ST_EXEC: begin
					if (sts.needs_move) begin
						state_q <= ST_COPY;
					end else if (sts.out_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				ST_COPY: begin
					if (sts.copy_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/lbbh_datapath.sv =====
// datapath: indices, config registers, byte store, compact mover, result register
// depends on lbbh_pkg and lbbh_ram
`default_nettype none

module lbbh_datapath #(
	parameter int STORE_DEPTH = lbbh_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lbbh_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [lbbh_pkg::IDX_W-1:0]     cfg_data,
	input  wire logic [lbbh_pkg::CMD_W-1:0]     cmd,
	input  wire logic [lbbh_pkg::BYTE_W-1:0]    byte_in,
	input  wire logic                           out_stall,
	output logic                                out_valid,
	output logic      [lbbh_pkg::BYTE_W-1:0]    byte_out,
	output logic                                done_res,
	output logic      [lbbh_pkg::IDX_W-1:0]     readable_count,
	output logic      [lbbh_pkg::IDX_W-1:0]     writable_count,
	output logic                                can_prepend,
	output logic                                in_headroom,
	input  wire lbbh_pkg::ctl_t                 ctl,
	output lbbh_pkg::sts_t                      sts
);

	localparam int IW = lbbh_pkg::IDX_W;
	localparam int BW = lbbh_pkg::BYTE_W;
	localparam int EW = lbbh_pkg::EXT_W;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [EW-1:0] DEPTH_EXT = EW'(STORE_DEPTH);

	function automatic logic [IW-1:0] eff_cap_f(input logic [IW-1:0] cap);
		logic [EW-1:0] cap_ext;
		cap_ext = {{(EW-IW){1'b0}}, cap};
		return (cap_ext > DEPTH_EXT) ? DEPTH_EXT[IW-1:0] : cap;
	endfunction

	function automatic logic [IW-1:0] eff_base_f(input logic [IW-1:0] hr,
		input logic [IW-1:0] cap_eff);
		return (hr > cap_eff) ? cap_eff : hr;
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
		logic [EW-1:0] idx_ext;
		idx_ext = {{(EW-IW){1'b0}}, idx};
		return idx_ext[AW-1:0];
	endfunction

	logic [IW-1:0]        hr_q, cap_q, rd_q, wr_q;
	lbbh_pkg::cmd_t       cmd_q;
	logic [BW-1:0]        byte_q;

	logic [IW-1:0]        src_q, dst_q, rcnt_q, n_q;
	logic                 dir_down_q;
	logic                 cp_v_s1;

	logic                 out_valid_q;
	logic [BW-1:0]        byte_out_q;
	logic                 done_q;
	logic [IW-1:0]        readable_q, writable_q;
	logic                 can_prepend_q, in_headroom_q;

	logic [IW-1:0]        cap_eff, base_eff, live_n;
	logic [IW:0]          fit_sum;
	logic                 fits;

	logic                 cfg_hit;
	logic [IW-1:0]        hr_new, cap_new, cfg_base;

	logic [IW-1:0]        rd_n, wr_n;
	logic                 done_n;
	logic [BW-1:0]        bout_n;
	logic                 cmd_we;
	logic [IW-1:0]        cmd_widx;

	logic                 load;
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [BW-1:0]        ram_wdata, ram_rdata;
	logic                 rd_step;

	assign cap_eff  = eff_cap_f(cap_q);
	assign base_eff = eff_base_f(hr_q, cap_eff);
	assign live_n   = wr_q - rd_q;
	assign fit_sum  = {1'b0, base_eff} + {1'b0, live_n};
	assign fits     = fit_sum <= {1'b0, cap_eff};

	// config write decode
	assign cfg_hit  = cfg_we && ((cfg_index == lbbh_pkg::REG_HEADROOM) ||
		(cfg_index == lbbh_pkg::REG_CAPACITY));
	assign hr_new   = (cfg_index == lbbh_pkg::REG_HEADROOM) ? cfg_data : hr_q;
	assign cap_new  = (cfg_index == lbbh_pkg::REG_CAPACITY) ? cfg_data : cap_q;
	assign cfg_base = eff_base_f(hr_new, eff_cap_f(cap_new));

	assign sts.needs_move = (cmd_q == lbbh_pkg::CMD_COMPACT) && (rd_q != base_eff) &&
		(rd_q != wr_q) && fits;
	assign sts.copy_done  = (rcnt_q == '0) && !cp_v_s1;
	assign sts.out_free   = !out_valid_q || !out_stall;

	// command evaluation
	always_comb begin
		rd_n     = rd_q;
		wr_n     = wr_q;
		done_n   = 1'b0;
		bout_n   = '0;
		cmd_we   = 1'b0;
		cmd_widx = wr_q;
		if (ctl.finish) begin
			rd_n   = base_eff;
			wr_n   = base_eff + n_q;
			done_n = 1'b1;
		end else begin
			unique case (cmd_q)
				lbbh_pkg::CMD_APPEND: begin
					if (wr_q < cap_eff) begin
						cmd_we = 1'b1;
						wr_n   = wr_q + 1'b1;
						done_n = 1'b1;
					end
				end
				lbbh_pkg::CMD_POP: begin
					if (rd_q < wr_q) begin
						bout_n = ram_rdata;
						done_n = 1'b1;
						if (rd_q + 1'b1 == wr_q) begin
							rd_n = base_eff;
							wr_n = base_eff;
						end else begin
							rd_n = rd_q + 1'b1;
						end
					end
				end
				lbbh_pkg::CMD_PEEK: begin
					if (rd_q < wr_q) begin
						bout_n = ram_rdata;
						done_n = 1'b1;
					end
				end
				lbbh_pkg::CMD_PREPEND: begin
					if (rd_q != '0) begin
						rd_n     = rd_q - 1'b1;
						cmd_we   = 1'b1;
						cmd_widx = rd_q - 1'b1;
						done_n   = 1'b1;
					end
				end
				lbbh_pkg::CMD_COMPACT: begin
					if (rd_q == base_eff) begin
						done_n = 1'b1;
					end else if (rd_q == wr_q) begin
						rd_n   = base_eff;
						wr_n   = base_eff;
						done_n = 1'b1;
					end
				end
				lbbh_pkg::CMD_CLEAR: begin
					rd_n   = base_eff;
					wr_n   = base_eff;
					done_n = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign load    = ctl.apply || ctl.finish;
	assign rd_step = ctl.copy_run && (rcnt_q != '0);

	// store port muxing
	always_comb begin
		ram_re    = ctl.accept || rd_step;
		ram_raddr = ctl.accept ? to_addr(rd_q) : to_addr(src_q);
		if (ctl.copy_run && cp_v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = to_addr(dst_q);
			ram_wdata = ram_rdata;
		end else begin
			ram_we    = ctl.apply && cmd_we;
			ram_waddr = to_addr(cmd_widx);
			ram_wdata = byte_q;
		end
	end

	lbbh_ram #(
		.WIDTH(BW),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hr_q        <= lbbh_pkg::HEADROOM_RST;
			cap_q       <= lbbh_pkg::CAPACITY_RST;
			rd_q        <= '0;
			wr_q        <= '0;
			rcnt_q      <= '0;
			cp_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_hit) begin
				hr_q <= hr_new;
				cap_q <= cap_new;
				rd_q <= cfg_base;
				wr_q <= cfg_base;
			end else if (load) begin
				rd_q <= rd_n;
				wr_q <= wr_n;
			end

			if (ctl.copy_start) begin
				rcnt_q  <= live_n;
				cp_v_s1 <= 1'b0;
			end else if (ctl.copy_run) begin
				cp_v_s1 <= rd_step;
				if (rd_step) begin
					rcnt_q <= rcnt_q - 1'b1;
				end
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q  <= lbbh_pkg::cmd_t'(cmd);
			byte_q <= byte_in;
		end

		// moving up copies from the top down
		if (ctl.copy_start) begin
			n_q        <= live_n;
			dir_down_q <= rd_q < base_eff;
			if (rd_q < base_eff) begin
				src_q <= wr_q - 1'b1;
				dst_q <= base_eff + live_n - 1'b1;
			end else begin
				src_q <= rd_q;
				dst_q <= base_eff;
			end
		end else if (ctl.copy_run) begin
			if (rd_step) begin
				src_q <= dir_down_q ? src_q - 1'b1 : src_q + 1'b1;
			end
			if (cp_v_s1) begin
				dst_q <= dir_down_q ? dst_q - 1'b1 : dst_q + 1'b1;
			end
		end

		if (load) begin
			byte_out_q    <= bout_n;
			done_q        <= done_n;
			readable_q    <= wr_n - rd_n;
			writable_q    <= cap_eff - wr_n;
			can_prepend_q <= rd_n != '0;
			in_headroom_q <= rd_n < base_eff;
		end
	end

	assign out_valid      = out_valid_q;
	assign byte_out       = byte_out_q;
	assign done_res       = done_q;
	assign readable_count = readable_q;
	assign writable_count = writable_q;
	assign can_prepend    = can_prepend_q;
	assign in_headroom    = in_headroom_q;

endmodule

`default_nettype wire

// ===== design/linear_byte_buffer_with_headroom_core.sv =====
// a command passes through accept and execute before its result is registered;
// compact with a move adds a copy and a finish step for its live bytes, one byte a cycle
// through the store's single read and single write port.
// one command at a time: in_stall holds off the next until the current result is registered.
// reset: indices 0, headroom 0, capacity 2048; store contents undefined.
`default_nettype none

module linear_byte_buffer_with_headroom_core #(
	parameter int STORE_DEPTH = lbbh_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lbbh_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [lbbh_pkg::IDX_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [lbbh_pkg::CMD_W-1:0]     cmd,
	input  wire logic [lbbh_pkg::BYTE_W-1:0]    byte_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [lbbh_pkg::BYTE_W-1:0]    byte_out,
	output logic                                done_res,
	output logic      [lbbh_pkg::IDX_W-1:0]     readable_count,
	output logic      [lbbh_pkg::IDX_W-1:0]     writable_count,
	output logic                                can_prepend,
	output logic                                in_headroom
);

	lbbh_pkg::ctl_t ctl;
	lbbh_pkg::sts_t sts;

	lbbh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.ctl     (ctl)
	);

	lbbh_datapath #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.byte_in       (byte_in),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.byte_out      (byte_out),
		.done_res      (done_res),
		.readable_count(readable_count),
		.writable_count(writable_count),
		.can_prepend   (can_prepend),
		.in_headroom   (in_headroom),
		.ctl           (ctl),
		.sts           (sts)
	);

endmodule

`default_nettype wire

// ===== design/lbbh_checker.sv =====
// port-level checker for the linear byte buffer core, bound to the top level
// depends on lbbh_pkg and linear_byte_buffer_with_headroom_core_defines.svh
`default_nettype none
`include "linear_byte_buffer_with_headroom_core_defines.svh"

module lbbh_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [lbbh_pkg::BYTE_W-1:0]    byte_out,
	input wire logic                           done_res,
	input wire logic [lbbh_pkg::IDX_W-1:0]     readable_count,
	input wire logic                           in_headroom
);

	`LBBH_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
	`LBBH_ASSERT(a_one_in_flight, clk, arst_n, in_valid && !in_stall |=> in_stall, "second transfer taken while busy")
	`LBBH_ASSERT(a_refused_zero, clk, arst_n, out_valid && !done_res |-> byte_out == '0, "refused command returned a byte")
	`LBBH_ASSERT(a_empty_at_base, clk, arst_n, out_valid && readable_count == '0 |-> !in_headroom, "empty buffer left below base")

endmodule

bind linear_byte_buffer_with_headroom_core lbbh_checker u_lbbh_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for linear_byte_buffer_with_headroom_core: a queue-fed driver sends buffer
// commands, a shadow store predicts every status transfer and a monitor checks each field
// depends on lbbh_pkg and the core rtl only
`timescale 1ns / 100ps

module tb;
	import lbbh_pkg::*;

	localparam logic [CMD_W-1:0]     CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0]     CMD_SPARE_7 = 3'd7;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int unsigned          DEPTH       = STORE_DEPTH_DEF;
	localparam int                   PRINT_MAX   = 200;

	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [BYTE_W-1:0] data;
	} buf_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rd_byte;
		logic              ok;
		logic [IDX_W-1:0]  n_readable;
		logic [IDX_W-1:0]  n_writable;
		logic              prep_ok;
		logic              below_base;
	} buf_status_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [IDX_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [CMD_W-1:0]     cmd       = '0;
	logic [BYTE_W-1:0]    byte_in   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [BYTE_W-1:0]    byte_out;
	logic                 done_res;
	logic [IDX_W-1:0]     readable_count;
	logic [IDX_W-1:0]     writable_count;
	logic                 can_prepend;
	logic                 in_headroom;

	// shadow copy of the buffer
	logic [BYTE_W-1:0] shadow_mem [DEPTH];
	int unsigned       rd_ptr, wr_ptr, headroom_reg, capacity_reg;

	buf_cmd_t    cmd_queue[$];
	buf_status_t status_queue[$];

	int mismatch_count = 0;
	int cmds_sent      = 0;
	int status_checked = 0;
	int refused_count  = 0;
	int reg_writes     = 0;
	bit send_steady    = 1'b0;
	bit recv_steady    = 1'b0;
	int hold_request   = 0;
	int hold_left      = 0;

	linear_byte_buffer_with_headroom_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.byte_in        (byte_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.byte_out       (byte_out),
		.done_res       (done_res),
		.readable_count (readable_count),
		.writable_count (writable_count),
		.can_prepend    (can_prepend),
		.in_headroom    (in_headroom)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("linear_byte_buffer_with_headroom_core test failed");
		$finish;
	end

	function automatic int unsigned cap_limit();
		return (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
	endfunction

	function automatic int unsigned base_point();
		int unsigned c;
		c = cap_limit();
		return (headroom_reg > c) ? c : headroom_reg;
	endfunction

	task automatic rewind_to_base();
		rd_ptr = base_point();
		wr_ptr = rd_ptr;
	endtask

	// next status for one accepted command, shadow state updated
	task automatic predict_status(input buf_cmd_t c);
		int unsigned       lim, base, n;
		logic [BYTE_W-1:0] moved [DEPTH];
		buf_status_t       s;
		lim  = cap_limit();
		base = base_point();
		s    = '0;
		case (c.op)
			CMD_APPEND: begin
				if (wr_ptr < lim) begin
					shadow_mem[wr_ptr] = c.data;
					wr_ptr++;
					s.ok = 1'b1;
				end
			end
			CMD_POP: begin
				if (rd_ptr < wr_ptr) begin
					s.rd_byte = shadow_mem[rd_ptr];
					rd_ptr++;
					if (rd_ptr == wr_ptr)
						rewind_to_base();
					s.ok = 1'b1;
				end
			end
			CMD_PEEK: begin
				if (rd_ptr < wr_ptr) begin
					s.rd_byte = shadow_mem[rd_ptr];
					s.ok = 1'b1;
				end
			end
			CMD_PREPEND: begin
				if (rd_ptr > 0) begin
					rd_ptr--;
					shadow_mem[rd_ptr] = c.data;
					s.ok = 1'b1;
				end
			end
			CMD_COMPACT: begin
				if (rd_ptr == base) begin
					s.ok = 1'b1;
				end else if (rd_ptr == wr_ptr) begin
					rewind_to_base();
					s.ok = 1'b1;
				end else begin
					n = wr_ptr - rd_ptr;
					if (base + n <= lim) begin
						for (int i = 0; i < n; i++)
							moved[i] = shadow_mem[rd_ptr + i];
						for (int i = 0; i < n; i++)
							shadow_mem[base + i] = moved[i];
						rd_ptr = base;
						wr_ptr = base + n;
						s.ok = 1'b1;
					end
				end
			end
			CMD_CLEAR: begin
				rewind_to_base();
				s.ok = 1'b1;
			end
			default: ;
		endcase
		s.n_readable = IDX_W'(wr_ptr - rd_ptr);
		s.n_writable = IDX_W'(lim - wr_ptr);
		s.prep_ok    = (rd_ptr > 0);
		s.below_base = (rd_ptr < base);
		if (!s.ok)
			refused_count++;
		status_queue.push_back(s);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < PRINT_MAX)
			$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[IDX_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HEADROOM)
			headroom_reg = {20'd0, value[IDX_W-1:0]};
		else if (idx == REG_CAPACITY)
			capacity_reg = {20'd0, value[IDX_W-1:0]};
		if (idx == REG_HEADROOM || idx == REG_CAPACITY)
			rewind_to_base();
		reg_writes++;
	endtask

	task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] data);
		cmd_queue.push_back({op, data});
	endtask

	// sampled on the falling edge so that the driver's updates have settled
	task automatic wait_drained();
		@(negedge clk);
		while (in_valid || cmd_queue.size() != 0 || status_queue.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	// bursts of fills, drains and prepends with random bytes, plus pop-compact pairs and loose commands
	task automatic queue_random_phase(input int n_items, input int burst_max);
		int left, k, pick;
		left = n_items;
		while (left > 0) begin
			pick = $urandom_range(99);
			k = $urandom_range(burst_max, 1);
			if (k > left)
				k = left;
			if (pick < 30) begin
				repeat (k) push_cmd(CMD_APPEND, BYTE_W'($urandom_range(255)));
			end else if (pick < 50) begin
				repeat (k) push_cmd(CMD_POP, BYTE_W'($urandom_range(255)));
			end else if (pick < 60) begin
				repeat (k) push_cmd(CMD_PREPEND, BYTE_W'($urandom_range(255)));
			end else if (pick < 70) begin
				k = 2;
				push_cmd(CMD_POP, BYTE_W'($urandom_range(255)));
				push_cmd(CMD_COMPACT, BYTE_W'($urandom_range(255)));
			end else begin
				k = 1;
				push_cmd(CMD_W'($urandom_range(7)), BYTE_W'($urandom_range(255)));
			end
			left -= k;
		end
	endtask

	// sender
	always @(posedge clk) begin : drive_cmds
		buf_cmd_t next_cmd;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_status({cmd, byte_in});
				cmds_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (cmd_queue.size() != 0 && (send_steady || $urandom_range(99) >= 11)) begin
					next_cmd = cmd_queue.pop_front();
					in_valid <= 1'b1;
					cmd      <= next_cmd.op;
					byte_in  <= next_cmd.data;
				end else begin
					in_valid <= 1'b0;
					cmd      <= CMD_W'($urandom_range(7));
					byte_in  <= BYTE_W'($urandom_range(255));
				end
			end
		end
	end

	// receiver stall, with a long hold-off on request
	always @(posedge clk) begin : drive_stall
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !recv_steady && ($urandom_range(99) < 11);
		end
	end

	always @(posedge clk) begin : check_status
		buf_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			status_checked++;
			if (status_queue.size() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
			end else begin
				want = status_queue.pop_front();
				if (byte_out !== want.rd_byte)
					report_mismatch("byte_out", byte_out, want.rd_byte);
				if (done_res !== want.ok)
					report_mismatch("done_res", done_res, want.ok);
				if (readable_count !== want.n_readable)
					report_mismatch("readable_count", readable_count, want.n_readable);
				if (writable_count !== want.n_writable)
					report_mismatch("writable_count", writable_count, want.n_writable);
				if (can_prepend !== want.prep_ok)
					report_mismatch("can_prepend", can_prepend, want.prep_ok);
				if (in_headroom !== want.below_base)
					report_mismatch("in_headroom", in_headroom, want.below_base);
			end
		end
	end

	initial begin : run
		int unsigned hr, cp;
		int burst_max;
		headroom_reg = {20'd0, HEADROOM_RST};
		capacity_reg = {20'd0, CAPACITY_RST};
		rd_ptr = 0;
		wr_ptr = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty buffer at reset settings
		push_cmd(CMD_POP, 8'h00);
		push_cmd(CMD_PEEK, 8'h00);
		push_cmd(CMD_PREPEND, 8'h5a);
		push_cmd(CMD_COMPACT, 8'h00);
		push_cmd(CMD_APPEND, 8'hff);
		push_cmd(CMD_PEEK, 8'h00);
		push_cmd(CMD_POP, 8'h00);
		push_cmd(CMD_SPARE_6, 8'h00);
		push_cmd(CMD_SPARE_7, 8'hff);
		wait_drained();

		// small window: fill, full, compact down, headroom prepends, overflowing compact, compact up
		write_reg(REG_HEADROOM, 2);
		write_reg(REG_CAPACITY, 6);
		push_cmd(CMD_APPEND, 8'h11);
		push_cmd(CMD_APPEND, 8'h22);
		push_cmd(CMD_APPEND, 8'h33);
		push_cmd(CMD_APPEND, 8'h44);
		push_cmd(CMD_APPEND, 8'h55);
		push_cmd(CMD_POP, 8'h00);
		push_cmd(CMD_COMPACT, 8'h00);
		push_cmd(CMD_PREPEND, 8'haa);
		push_cmd(CMD_PREPEND, 8'hbb);
		push_cmd(CMD_PREPEND, 8'hcc);
		push_cmd(CMD_COMPACT, 8'h00);
		push_cmd(CMD_CLEAR, 8'h00);
		push_cmd(CMD_PREPEND, 8'h0f);
		push_cmd(CMD_COMPACT, 8'h00);
		wait_drained();

		// no room at all, then both registers at all ones
		write_reg(REG_CAPACITY, 0);
		push_cmd(CMD_APPEND, 8'h00);
		wait_drained();
		write_reg(REG_CAPACITY, 12'hfff);
		write_reg(REG_HEADROOM, 12'hfff);
		push_cmd(CMD_PREPEND, 8'h00);
		push_cmd(CMD_POP, 8'h00);
		wait_drained();

		for (int phase = 0; phase < 10; phase++) begin
			burst_max = 12;
			case (phase)
				0: begin
					hr = 0;
					cp = 2048;
					burst_max = 40;
				end
				1: begin
					hr = 100;
					cp = 2048;
					burst_max = 40;
				end
				2: begin
					hr = 0;
					cp = 1;
				end
				3: begin
					hr = 20;
					cp = 9;
				end
				default: begin
					hr = $urandom_range(16);
					cp = $urandom_range(48, 1);
				end
			endcase
			write_reg(REG_CAPACITY, cp);
			write_reg(REG_HEADROOM, hr);
			if (phase == 2) begin
				write_reg(REG_SPARE_2, 12'h0f0);
				write_reg(REG_SPARE_3, 12'hfff);
			end
			send_steady = (phase == 4);
			recv_steady = (phase == 4);
			queue_random_phase(75, burst_max);
			if (phase == 6)
				hold_request = 400;
			wait_drained();
		end

		repeat (20) @(posedge clk);
		$display("ran %0d commands over %0d register writes, %0d refused by the buffer",
			cmds_sent, reg_writes, refused_count);
		$display("checked %0d status transfers, %0d mismatches", status_checked,
			mismatch_count);
		if (mismatch_count == 0 && status_queue.size() == 0) begin
			$display("linear_byte_buffer_with_headroom_core test passed");
		end else begin
			$display("linear_byte_buffer_with_headroom_core test failed");
		end
		$finish;
	end

endmodule
